// ===== sv/qte_pkg.sv =====
// Shared types, constants and the arctangent table of the quaternion to Euler angle converter.
package qte_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Working format: 30 fraction bits; all sums of products stay below 2^36
  localparam int WORK_FRAC = 30;
  localparam int WW        = 40;
  // Angle accumulator: quadrant offset plus the whole arctangent series
  localparam int ZW        = 34;
  localparam int ANG_W     = 16;
  localparam int PITCH_W   = 15;

  // Square root of (2^60 - s^2): 61-bit radicand, 31-bit root
  localparam int ABS_W    = 31;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int RAD_W    = 61;
  localparam int ROOT_W   = 31;
  localparam int ROOT_TOP = ROOT_W - 1;
  localparam int TRIAL_W  = 64;

  localparam int ROUND_SH = 17;

  typedef logic signed [WW-1:0] work_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam work_t ONE_W      = work_t'(64'sd1 <<< WORK_FRAC);
  localparam ang_t  HALF_PI_W  = ang_t'(64'sd1686629713);
  localparam ang_t  ROUND_BIAS = ang_t'(64'sd1 <<< (ROUND_SH - 1));
  localparam logic signed [ANG_W-1:0]   PI_Q13      = 16'sd25736;
  localparam logic signed [PITCH_W-1:0] HALF_PI_Q13 = 15'sd12868;

  localparam ang_t ATAN_HEAD [10] = '{
    ang_t'(64'sd843314857), ang_t'(64'sd497837829), ang_t'(64'sd263043837),
    ang_t'(64'sd133525159), ang_t'(64'sd67021687),  ang_t'(64'sd33543516),
    ang_t'(64'sd16775851),  ang_t'(64'sd8388437),   ang_t'(64'sd4194283),
    ang_t'(64'sd2097149)
  };

  // Terms of the three angle formulas in working format
  typedef struct packed {
    work_t rs;
    work_t rc;
    work_t sp;
    work_t ys;
    work_t yc;
  } terms_t;

  // Terms carried alongside the square root, with the pitch clamp flags
  typedef struct packed {
    terms_t t;
    logic   sat_pos;
    logic   sat_neg;
  } side_t;

  // One CORDIC vectoring lane
  typedef struct packed {
    work_t x;
    work_t y;
    ang_t  z;
    logic  zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
    logic  sat_pos;
    logic  sat_neg;
  } rot_t;

  // Arctangent of 2^-i in working radians
  function automatic ang_t atan_step(input int unsigned i);
    if (i < 10) begin
      return ATAN_HEAD[i];
    end else if (i <= 30) begin
      return ang_t'(64'sd1 <<< (30 - i));
    end
    return '0;
  endfunction

endpackage

// ===== sv/quaternion_to_euler_angles_core.sv =====
// Top level: quaternion (Q2.14) to ZYX roll, yaw (Q3.13) and pitch (Q2.13) pipeline.
//
// Input channel in_*: one quaternion request per in_valid & in_ready edge.
// Output channel out_*: roll, pitch and yaw of that request, in order.
// Unstalled, the pipeline takes one request and returns one result per cycle.
// A request passes 38 + CORDIC_STEPS register stages (54 at the default of
// 16 steps): two for products and sums, three for the pitch clamp, square
// and radicand, 31 for the square root (one root bit each), one pre-rotation,
// one per CORDIC iteration and one for rounding into the output register.
// The whole pipeline moves on one enable; valid bits travel with the data.
// When the receiver holds out_ready low with a result waiting, every stage
// holds and in_ready drops; while out_valid is low, every stage advances
// and in_ready stays high.
// Reset clears all valid bits; data registers keep their contents.
module quaternion_to_euler_angles_core import qte_pkg::*; #(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_quat_w,
  input  logic signed [DATA_WIDTH-1:0] in_quat_x,
  input  logic signed [DATA_WIDTH-1:0] in_quat_y,
  input  logic signed [DATA_WIDTH-1:0] in_quat_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ANG_W-1:0]      out_roll_angle,
  output logic signed [PITCH_W-1:0]    out_pitch_angle,
  output logic signed [ANG_W-1:0]      out_yaw_angle
);

  logic   en;
  logic   p2_v;
  terms_t p2_terms;

  logic               s3_v_r;
  side_t              s3_side_r;
  side_t              s3_side_nxt;
  logic [ABS_W-1:0]   s3_abs_r;
  logic [ABS_W-1:0]   s3_abs_nxt;
  logic               s4_v_r;
  side_t              s4_side_r;
  logic [SQ_W-1:0]    s4_sq_r;
  logic [SQ_W-1:0]    s4_sq_nxt;
  logic               s5_v_r;
  side_t              s5_side_r;
  logic [RAD_W-1:0]   s5_rad_r;
  logic [RAD_W-1:0]   s5_rad_nxt;

  logic               sq_v    [ROOT_W+1];
  logic [RAD_W-1:0]   sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root [ROOT_W+1];
  side_t              sq_side [ROOT_W+1];

  logic               pr_v_r;
  rot_t               pr_r;
  rot_t               pr_nxt;

  logic               cd_v   [CORDIC_STEPS+1];
  rot_t               cd_rot [CORDIC_STEPS+1];

  logic                       out_v_r;
  logic signed [ANG_W-1:0]    roll_r;
  logic signed [ANG_W-1:0]    roll_nxt;
  logic signed [PITCH_W-1:0]  pitch_r;
  logic signed [PITCH_W-1:0]  pitch_nxt;
  logic signed [ANG_W-1:0]    yaw_r;
  logic signed [ANG_W-1:0]    yaw_nxt;

  // Move every stage unless a finished result is stuck at the output
  assign en       = out_ready | ~out_v_r;
  assign in_ready = en;

  qte_prod #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prod (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .qw    (in_quat_w),
    .qx    (in_quat_x),
    .qy    (in_quat_y),
    .qz    (in_quat_z),
    .out_v (p2_v),
    .terms (p2_terms)
  );

  // Stage 3: pitch clamp flags and magnitude of the asin argument
  always_comb begin
    work_t mag;
    s3_side_nxt.t       = p2_terms;
    s3_side_nxt.sat_pos = p2_terms.sp >= ONE_W;
    s3_side_nxt.sat_neg = p2_terms.sp <= -ONE_W;
    mag                 = p2_terms.sp[WW-1] ? -p2_terms.sp : p2_terms.sp;
    s3_abs_nxt          = mag[ABS_W-1:0];
  end

  // Stage 4: square the argument
  assign s4_sq_nxt = SQ_W'(s3_abs_r) * SQ_W'(s3_abs_r);

  // Stage 5: radicand 1 - s^2 at 60 fraction bits
  assign s5_rad_nxt = RAD_W'((SQ_W'(1) << (2 * WORK_FRAC)) - s4_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= p2_v;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r <= s3_side_nxt;
      s3_abs_r  <= s3_abs_nxt;
      s4_side_r <= s3_side_r;
      s4_sq_r   <= s4_sq_nxt;
      s5_side_r <= s4_side_r;
      s5_rad_r  <= s5_rad_nxt;
    end
  end

  // Square root, one root bit per stage from the top
  assign sq_v[0]    = s5_v_r;
  assign sq_rem[0]  = s5_rad_r;
  assign sq_root[0] = '0;
  assign sq_side[0] = s5_side_r;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    qte_sqrt_stage #(
      .BIT (ROOT_TOP - g)
    ) u_sqrt (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (sq_v[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .side_in  (sq_side[g]),
      .out_v    (sq_v[g+1]),
      .rem_out  (sq_rem[g+1]),
      .root_out (sq_root[g+1]),
      .side_out (sq_side[g+1])
    );
  end

  // Quadrant pre-rotation so that x is not negative
  function automatic lane_t prerot(input work_t x, input work_t y);
    lane_t l;
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    l.zero = (x == '0) && (y == '0);
    if (x[WW-1]) begin
      if (!y[WW-1]) begin
        l.x = y;
        l.y = -x;
        l.z = HALF_PI_W;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -HALF_PI_W;
      end
    end
    return l;
  endfunction

  always_comb begin
    side_t s;
    s               = sq_side[ROOT_W];
    pr_nxt.roll     = prerot(s.t.rc, s.t.rs);
    pr_nxt.pitch    = prerot(work_t'(sq_root[ROOT_W]), s.t.sp);
    pr_nxt.yaw      = prerot(s.t.yc, s.t.ys);
    pr_nxt.sat_pos  = s.sat_pos;
    pr_nxt.sat_neg  = s.sat_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else if (en) begin
      pr_v_r <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r <= pr_nxt;
    end
  end

  // CORDIC vectoring, one iteration per stage
  assign cd_v[0]   = pr_v_r;
  assign cd_rot[0] = pr_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    qte_cordic_stage #(
      .STEP (g)
    ) u_cordic (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (cd_v[g]),
      .rot_in  (cd_rot[g]),
      .out_v   (cd_v[g+1]),
      .rot_out (cd_rot[g+1])
    );
  end

  // Round to Q3.13 (ties up) and saturate to the given limit
  function automatic logic signed [ANG_W-1:0] to_q13(input lane_t l,
                                                     input logic signed [ANG_W-1:0] lim);
    ang_t r;
    ang_t lim_w;
    r     = (l.z + ROUND_BIAS) >>> ROUND_SH;
    lim_w = ang_t'(lim);
    if (r > lim_w) begin
      r = lim_w;
    end else if (r < -lim_w) begin
      r = -lim_w;
    end
    if (l.zero) begin
      r = '0;
    end
    return r[ANG_W-1:0];
  endfunction

  always_comb begin
    rot_t f;
    logic signed [ANG_W-1:0] p;
    f        = cd_rot[CORDIC_STEPS];
    roll_nxt = to_q13(f.roll, PI_Q13);
    yaw_nxt  = to_q13(f.yaw, PI_Q13);
    p        = to_q13(f.pitch, ANG_W'(HALF_PI_Q13));
    if (f.sat_pos) begin
      pitch_nxt = HALF_PI_Q13;
    end else if (f.sat_neg) begin
      pitch_nxt = -HALF_PI_Q13;
    end else begin
      pitch_nxt = p[PITCH_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= cd_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;

endmodule

// ===== sv/qte_prod.sv =====
// Front end: full-width products, then the roll, pitch and yaw terms in working format.
module qte_prod import qte_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  logic signed [DATA_WIDTH-1:0] qw,
  input  logic signed [DATA_WIDTH-1:0] qx,
  input  logic signed [DATA_WIDTH-1:0] qy,
  input  logic signed [DATA_WIDTH-1:0] qz,
  output logic                         out_v,
  output terms_t                       terms
);

  localparam int PW  = 2 * DATA_WIDTH;
  localparam int SH  = 2 * (DATA_WIDTH - 2) - WORK_FRAC;
  localparam int RSH = (SH > 0) ? SH : 0;
  localparam int LSH = (SH < 0) ? -SH : 0;
  localparam int MW  = (PW > WW) ? PW : WW;

  localparam int P_WX = 0;
  localparam int P_YZ = 1;
  localparam int P_XX = 2;
  localparam int P_YY = 3;
  localparam int P_WY = 4;
  localparam int P_ZX = 5;
  localparam int P_WZ = 6;
  localparam int P_XY = 7;
  localparam int P_ZZ = 8;
  localparam int NP   = 9;

  typedef logic signed [PW-1:0] prod_t;

  prod_t  prod_nxt [NP];
  prod_t  prod_r   [NP];
  logic   v1_r;
  logic   v2_r;
  terms_t terms_nxt;
  terms_t terms_r;

  // Bring a product to 30 fraction bits, flooring when bits drop
  function automatic work_t to_w(input prod_t p);
    logic signed [MW-1:0] e;
    e = MW'(p);
    e = (e >>> RSH) <<< LSH;
    return work_t'(e);
  endfunction

  // Stage 1: nine products at full width
  always_comb begin
    prod_nxt[P_WX] = PW'(qw) * PW'(qx);
    prod_nxt[P_YZ] = PW'(qy) * PW'(qz);
    prod_nxt[P_XX] = PW'(qx) * PW'(qx);
    prod_nxt[P_YY] = PW'(qy) * PW'(qy);
    prod_nxt[P_WY] = PW'(qw) * PW'(qy);
    prod_nxt[P_ZX] = PW'(qz) * PW'(qx);
    prod_nxt[P_WZ] = PW'(qw) * PW'(qz);
    prod_nxt[P_XY] = PW'(qx) * PW'(qy);
    prod_nxt[P_ZZ] = PW'(qz) * PW'(qz);
  end

  // Stage 2: combine into the atan2 and asin operands
  always_comb begin
    terms_nxt.rs = (to_w(prod_r[P_WX]) + to_w(prod_r[P_YZ])) <<< 1;
    terms_nxt.rc = ONE_W - ((to_w(prod_r[P_XX]) + to_w(prod_r[P_YY])) <<< 1);
    terms_nxt.sp = (to_w(prod_r[P_WY]) - to_w(prod_r[P_ZX])) <<< 1;
    terms_nxt.ys = (to_w(prod_r[P_WZ]) + to_w(prod_r[P_XY])) <<< 1;
    terms_nxt.yc = ONE_W - ((to_w(prod_r[P_YY]) + to_w(prod_r[P_ZZ])) <<< 1);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      terms_r <= terms_nxt;
    end
  end

  assign out_v = v2_r;
  assign terms = terms_r;

endmodule

// ===== sv/qte_sqrt_stage.sv =====
// One bit of the restoring integer square root, registered.
module qte_sqrt_stage import qte_pkg::*; #(
  parameter int BIT = ROOT_TOP
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [RAD_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  input  side_t             side_in,
  output logic              out_v,
  output logic [RAD_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out,
  output side_t             side_out
);

  logic [TRIAL_W-1:0] trial;
  logic               take;
  logic [RAD_W-1:0]   rem_nxt;
  logic [ROOT_W-1:0]  root_nxt;
  logic               v_r;
  logic [RAD_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  side_t              side_r;

  // Try this root bit: subtract (2r + 2^k) * 2^k when it fits
  always_comb begin
    trial    = (TRIAL_W'(root_in) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
    take     = TRIAL_W'(rem_in) >= trial;
    rem_nxt  = take ? RAD_W'(TRIAL_W'(rem_in) - trial) : rem_in;
    root_nxt = take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_in;
    end
  end

  assign out_v    = v_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign side_out = side_r;

endmodule

// ===== sv/qte_cordic_stage.sv =====
// One CORDIC vectoring iteration on the roll, pitch and yaw lanes, registered.
module qte_cordic_stage import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_v,
  input  rot_t rot_in,
  output logic out_v,
  output rot_t rot_out
);

  localparam ang_t ATAN_K = atan_step(STEP);

  rot_t rot_nxt;
  rot_t rot_r;
  logic v_r;

  // Rotate toward y = 0 and accumulate the angle
  function automatic lane_t iter(input lane_t l);
    lane_t o;
    work_t dx;
    work_t dy;
    dx = l.x >>> STEP;
    dy = l.y >>> STEP;
    o  = l;
    if (!l.y[WW-1]) begin
      o.x = l.x + dy;
      o.y = l.y - dx;
      o.z = l.z + ATAN_K;
    end else begin
      o.x = l.x - dy;
      o.y = l.y + dx;
      o.z = l.z - ATAN_K;
    end
    return o;
  endfunction

  always_comb begin
    rot_nxt       = rot_in;
    rot_nxt.roll  = iter(rot_in.roll);
    rot_nxt.pitch = iter(rot_in.pitch);
    rot_nxt.yaw   = iter(rot_in.yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign out_v   = v_r;
  assign rot_out = rot_r;

endmodule

// ===== sv/qte_checker.sv =====
// Port checker for the converter top level, with its bind.
module qte_checker import qte_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [ANG_W-1:0]    out_roll_angle,
  input logic signed [PITCH_W-1:0]  out_pitch_angle,
  input logic signed [ANG_W-1:0]    out_yaw_angle
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_angle)
      && $stable(out_pitch_angle) && $stable(out_yaw_angle))
    else $error("result changed while stalled");

  // With no result waiting the pipeline takes requests
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // Pitch stays within plus or minus pi/2
  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= HALF_PI_Q13 && out_pitch_angle >= -HALF_PI_Q13)
    else $error("pitch out of range");

  // Roll and yaw stay within plus or minus pi
  a_ry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= PI_Q13 && out_roll_angle >= -PI_Q13
      && out_yaw_angle <= PI_Q13 && out_yaw_angle >= -PI_Q13)
    else $error("roll or yaw out of range");

  // Reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_roll_angle  (out_roll_angle),
  .out_pitch_angle (out_pitch_angle),
  .out_yaw_angle   (out_yaw_angle)
);

// ===== dv/quaternion_to_euler_angles_core_tb.sv =====
// Self-checking testbench of the quaternion to ZYX Euler angle converter.
module quaternion_to_euler_angles_core_tb;
  import qte_pkg::*;

  localparam int    N_RANDOM    = 1650;
  localparam int    CYCLE_LIMIT = 400000;
  localparam int    DRAIN       = 120;
  localparam longint ONE_W30    = 64'sd1 <<< 30;
  localparam longint HALF_PI_30 = 64'sd1686629713;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic signed [ANG_W-1:0]   roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ANG_W-1:0]   yaw;
  } euler_t;

  // Directed row: pitch is typed in only where it is the plain clamp
  typedef struct packed {
    q14_t w, x, y, z;
    logic pitch_known;
    logic signed [PITCH_W-1:0] pitch;
  } quat_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  q14_t in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic signed [ANG_W-1:0]   out_roll_angle, out_yaw_angle;
  logic signed [PITCH_W-1:0] out_pitch_angle;

  euler_t angle_q[$];
  int     n_fail = 0;
  int     cycle_cnt = 0;
  bit     send_idle = 1'b1, recv_idle = 1'b1;

  quaternion_to_euler_angles_core u_top (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Arctangent of 2^-i, 30 fraction bits
  function automatic longint atan_pow2(int i);
    longint head [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // Fold left half-plane into the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_30;
      end else begin
        x = -y; y = t; z = -HALF_PI_30;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += atan_pow2(i);
      end else begin
        x -= dy; y += dx; z -= atan_pow2(i);
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(longint z, longint lim);
    longint r;
    r = (z + (64'sd1 <<< 16)) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint mul30(q14_t a, q14_t b);
    return (longint'(a) * longint'(b)) * 4;
  endfunction

  function automatic euler_t euler_of(q14_t w, q14_t x, q14_t y, q14_t z);
    euler_t e;
    longint rs, rc, sp, ys, yc;
    longint unsigned s2;
    rs = 2 * (mul30(w, x) + mul30(y, z));
    rc = ONE_W30 - 2 * (mul30(x, x) + mul30(y, y));
    sp = 2 * (mul30(w, y) - mul30(z, x));
    ys = 2 * (mul30(w, z) + mul30(x, y));
    yc = ONE_W30 - 2 * (mul30(y, y) + mul30(z, z));
    e.roll = ANG_W'(round_q13(vector_angle(rs, rc), 25736));
    e.yaw  = ANG_W'(round_q13(vector_angle(ys, yc), 25736));
    // Clamp pitch at gimbal lock
    if (sp >= ONE_W30) begin
      e.pitch = HALF_PI_Q13;
    end else if (sp <= -ONE_W30) begin
      e.pitch = -HALF_PI_Q13;
    end else begin
      s2 = sp < 0 ? -sp : sp;
      e.pitch = PITCH_W'(round_q13(
        vector_angle(sp, longint'(root64((64'd1 << 60) - s2 * s2))), 12868));
    end
    return e;
  endfunction

  // Drive one request; returns at the falling edge after acceptance
  task automatic send_quat(q14_t w, q14_t x, q14_t y, q14_t z, logic pk,
                           logic signed [PITCH_W-1:0] pv);
    int gap;
    euler_t e;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_quat_w = w; in_quat_x = x; in_quat_y = y; in_quat_z = z;
    do @(posedge clk); while (!in_ready);
    e = euler_of(w, x, y, z);
    if (pk) e.pitch = pv;
    angle_q.push_back(e);
    @(negedge clk);
  endtask

  function automatic q14_t rand_q14(int mode);
    case (mode)
      0: return q14_t'($urandom);
      1: return q14_t'($urandom_range(0, 32768) - 16384);
      default: return q14_t'($urandom_range(0, 2048) - 1024);
    endcase
  endfunction

  // Stimulus
  initial begin
    quat_row_t rows [] = '{
      '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 15'sd0},
      '{16'sd0, 16'sd8192, 16'sd8192, 16'sd0, 1'b0, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd8192, 16'sd8192, 1'b0, 15'sd0},
      '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b1, 15'sd12868},
      '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 1'b1, -15'sd12868},
      '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 1'b0, 15'sd0},
      '{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 1'b0, 15'sd0},
      '{16'sd11586, 16'sd0, 16'sd11586, 16'sd0, 1'b0, 15'sd0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 15'sd0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 15'sd0},
      '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 15'sd0},
      '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 15'sd0},
      '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 15'sd0},
      '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 1'b0, 15'sd0},
      '{16'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b0, 15'sd0},
      '{-16'sd1, 16'sd0, 16'sd0, -16'sd1, 1'b0, 15'sd0},
      '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0, 15'sd0},
      '{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 1'b0, 15'sd0},
      '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, 15'sd0}
    };
    int mode;
    in_valid = 1'b0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i])
      send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z,
                rows[i].pitch_known, rows[i].pitch);
    for (int n = 0; n < N_RANDOM; n++) begin
      // Stretches with and without idling, chosen at random every 100 requests
      if (n % 100 == 0) send_idle = $urandom_range(0, 2) != 0;
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        send_quat(rand_q14(0), rand_q14(0), rand_q14(0), rand_q14(0), 1'b0, '0);
      end else if (mode < 8) begin
        send_quat(rand_q14(1), rand_q14(1), rand_q14(1), rand_q14(1), 1'b0, '0);
      end else begin
        // Near gimbal lock
        send_quat(q14_t'(11585 + rand_q14(2)), rand_q14(2),
                  q14_t'(mode[0] ? 11585 : -11585) + rand_q14(2), rand_q14(2), 1'b0, '0);
      end
    end
    in_valid = 1'b0;
    wait (angle_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (n_fail == 0) begin
      $display("quaternion_to_euler_angles_core verification clean");
    end else begin
      $display("quaternion_to_euler_angles_core verification failed");
    end
    $finish;
  end

  // Result side stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (($urandom_range(0, 199)) == 0) recv_idle = !recv_idle;
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_valid && out_ready) begin
      if (angle_q.size() == 0) begin
        $error("result with no request pending");
        n_fail++;
      end else begin
        e = angle_q.pop_front();
        if (out_roll_angle !== e.roll) begin
          $error("roll_angle expected %0d got %0d", e.roll, out_roll_angle);
          n_fail++;
        end
        if (out_pitch_angle !== e.pitch) begin
          $error("pitch_angle expected %0d got %0d", e.pitch, out_pitch_angle);
          n_fail++;
        end
        if (out_yaw_angle !== e.yaw) begin
          $error("yaw_angle expected %0d got %0d", e.yaw, out_yaw_angle);
          n_fail++;
        end
      end
    end
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("quaternion_to_euler_angles_core verification failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
sv/qte_pkg.sv
sv/qte_prod.sv
sv/qte_sqrt_stage.sv
sv/qte_cordic_stage.sv
sv/quaternion_to_euler_angles_core.sv
sv/qte_checker.sv
dv/quaternion_to_euler_angles_core_tb.sv
